@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/tibc_pkg.sv @@
package tibc_pkg;

  localparam logic [7:0]  TYPE_NAME  = 8'h55;
  localparam logic [7:0]  TYPE_DATA  = 8'h3C;
  localparam logic [7:0]  TYPE_ENTRY = 8'h78;
  localparam logic [8:0]  FULL_BLOCK = 9'd256;
  localparam logic [8:0]  NAME_LEN   = 9'd6;
  localparam logic [23:0] SIZE_MAX   = 24'hFFFFFF;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_BASIC     = 2'd1,
    MODE_SYSTEM    = 2'd2
  } tibc_mode_t;

  typedef enum logic [3:0] {
    PH_TYPE = 4'd0,
    PH_NAME = 4'd1,
    PH_LEN  = 4'd2,
    PH_ALO  = 4'd3,
    PH_AHI  = 4'd4,
    PH_DATA = 4'd5,
    PH_CSUM = 4'd6,
    PH_ELO  = 4'd7,
    PH_EHI  = 4'd8
  } tibc_phase_t;

  typedef enum logic [1:0] {
    BLK_NONE  = 2'd0,
    BLK_NAME  = 2'd1,
    BLK_DATA  = 2'd2,
    BLK_ENTRY = 2'd3
  } tibc_block_t;

  typedef enum logic [2:0] {
    ST_BUSY        = 3'd0,
    ST_DONE        = 3'd1,
    ST_DROPPED     = 3'd2,
    ST_CSUM_ERR    = 3'd3,
    ST_TRUNCATED   = 3'd4,
    ST_SECOND_NAME = 3'd5,
    ST_NO_NAME     = 3'd6,
    ST_BAD_TYPE    = 3'd7
  } tibc_status_t;

  typedef struct packed {
    tibc_mode_t   mode;
    tibc_phase_t  phase;
    logic [8:0]   field_count;
    logic [8:0]   block_length;
    logic [7:0]   block_sum;
    tibc_block_t  prev_block;
    logic [1:0]   zero_run;
    logic [31:0]  sum_total;
    logic [23:0]  size_total;
    tibc_status_t latched;
  } tibc_state_t;

  localparam tibc_state_t STATE_RESET = '{
    mode:         MODE_UNDECIDED,
    phase:        PH_TYPE,
    field_count:  9'd0,
    block_length: 9'd0,
    block_sum:    8'd0,
    prev_block:   BLK_NONE,
    zero_run:     2'd0,
    sum_total:    32'd0,
    size_total:   24'd0,
    latched:      ST_BUSY
  };

  typedef struct packed {
    logic [7:0]   out_value;
    logic         out_write;
    tibc_status_t status;
    tibc_mode_t   format_mode;
    logic [31:0]  unique_sum;
    logic [23:0]  code_size;
  } tibc_result_t;

endpackage

@@ rtl/tibc_if.sv @@
interface tibc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_image;

  modport source (output valid, output byte_value, output end_of_image, input ready);
  modport sink   (input valid, input byte_value, input end_of_image, output ready);
endinterface

interface tibc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_value;
  logic        out_write;
  logic [2:0]  status;
  logic [1:0]  format_mode;
  logic [31:0] unique_sum;
  logic [23:0] code_size;

  modport source (output valid, output out_value, output out_write, output status,
                  output format_mode, output unique_sum, output code_size, input ready);
  modport sink   (input valid, input out_value, input out_write, input status,
                  input format_mode, input unique_sum, input code_size, output ready);
endinterface

@@ rtl/tibc_cfg.sv @@
module tibc_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [47:0] rename_text
);

  logic [47:0] rename_r;
  logic        wr_en;

  // paddr[3] clear selects the only register; other offsets within it alias
  assign wr_en  = psel & penable & pwrite & pready & ~paddr[3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rename_r <= '0;
    end else if (wr_en) begin
      rename_r <= pwdata[47:0];
    end
  end

  assign prdata      = paddr[3] ? 64'd0 : {16'd0, rename_r};
  assign rename_text = rename_r;

endmodule

@@ rtl/tibc_step.sv @@
module tibc_step (
  input  tibc_pkg::tibc_state_t  cur,
  input  logic [7:0]             byte_value,
  input  logic                   end_of_image,
  input  logic [47:0]            rename_text,
  output tibc_pkg::tibc_state_t  nxt,
  output tibc_pkg::tibc_result_t res
);
  import tibc_pkg::*;

  function automatic logic [7:0] name_byte(input logic [2:0] idx, input logic [7:0] fb,
                                           input logic [47:0] txt);
    logic [7:0] r;
    r = fb;
    if (txt[7:0] != 8'd0) begin
      unique case (idx)
        3'd1:    r = txt[15:8];
        3'd2:    r = txt[23:16];
        3'd3:    r = txt[31:24];
        3'd4:    r = txt[39:32];
        3'd5:    r = txt[47:40];
        default: r = txt[7:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [8:0] n);
    logic [24:0] s;
    s = {1'b0, a} + {16'd0, n};
    return s[24] ? SIZE_MAX : s[23:0];
  endfunction

  logic         wr;
  logic [7:0]   val;
  tibc_status_t st;
  logic         sys;
  logic         is_type;
  logic         ok;
  logic [8:0]   cnt_inc;

  assign is_type = (byte_value == TYPE_NAME) || (byte_value == TYPE_DATA) ||
                   (byte_value == TYPE_ENTRY);
  assign ok      = ((cur.mode == MODE_SYSTEM) && (cur.phase == PH_TYPE)) ||
                   ((cur.mode == MODE_BASIC) && (cur.zero_run == 2'd3));
  assign cnt_inc = cur.field_count + 9'd1;

  always_comb begin
    nxt = cur;
    wr  = 1'b0;
    val = byte_value;
    st  = ST_BUSY;
    sys = 1'b0;

    if (cur.latched != ST_BUSY) begin
      st = cur.latched;
    end else if (end_of_image) begin
      st          = ok ? ST_DONE : ST_TRUNCATED;
      nxt.latched = st;
    end else if (cur.mode == MODE_UNDECIDED) begin
      if (is_type) begin
        nxt.mode = MODE_SYSTEM;
        sys      = 1'b1;
      end else begin
        // first BASIC byte is the name character
        nxt.mode = MODE_BASIC;
        wr       = 1'b1;
        val      = name_byte(3'd0, byte_value, rename_text);
      end
    end else if (cur.mode == MODE_BASIC) begin
      if (cur.zero_run == 2'd3) begin
        st = ST_DROPPED;
      end else begin
        wr             = 1'b1;
        nxt.sum_total  = cur.sum_total + {24'd0, byte_value};
        nxt.size_total = sat_add(cur.size_total, 9'd1);
        nxt.zero_run   = (byte_value != 8'd0) ? 2'd0 : cur.zero_run + 2'd1;
      end
    end else begin
      sys = 1'b1;
    end

    if (sys) begin
      wr = 1'b1;
      unique case (cur.phase)
        PH_TYPE: begin
          priority if (byte_value == TYPE_NAME) begin
            if (cur.prev_block != BLK_NONE) begin
              wr = 1'b0; st = ST_SECOND_NAME; nxt.latched = ST_SECOND_NAME;
            end else begin
              nxt.phase       = PH_NAME;
              nxt.field_count = 9'd0;
            end
          end else if (byte_value == TYPE_DATA) begin
            if (cur.prev_block == BLK_NONE) begin
              wr = 1'b0; st = ST_NO_NAME; nxt.latched = ST_NO_NAME;
            end else begin
              nxt.phase = PH_LEN;
            end
          end else if (byte_value == TYPE_ENTRY) begin
            nxt.phase = PH_ELO;
          end else if (cur.prev_block == BLK_DATA || cur.prev_block == BLK_ENTRY) begin
            wr = 1'b0; st = ST_DROPPED;
          end else begin
            wr = 1'b0; st = ST_BAD_TYPE; nxt.latched = ST_BAD_TYPE;
          end
        end
        PH_NAME: begin
          val             = name_byte(cur.field_count[2:0], byte_value, rename_text);
          nxt.field_count = cnt_inc;
          if (cnt_inc >= NAME_LEN) begin
            nxt.phase      = PH_TYPE;
            nxt.prev_block = BLK_NAME;
          end
        end
        PH_LEN: begin
          nxt.block_length = (byte_value == 8'd0) ? FULL_BLOCK : {1'b0, byte_value};
          nxt.block_sum    = 8'd0;
          nxt.field_count  = 9'd0;
          nxt.phase        = PH_ALO;
        end
        PH_ALO: begin
          nxt.block_sum = cur.block_sum + byte_value;
          nxt.phase     = PH_AHI;
        end
        PH_AHI: begin
          nxt.block_sum = cur.block_sum + byte_value;
          nxt.phase     = PH_DATA;
        end
        PH_DATA: begin
          nxt.block_sum   = cur.block_sum + byte_value;
          nxt.sum_total   = cur.sum_total + {24'd0, byte_value};
          nxt.field_count = cnt_inc;
          if (cnt_inc >= cur.block_length) begin
            nxt.phase = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (byte_value != cur.block_sum) begin
            wr = 1'b0; st = ST_CSUM_ERR; nxt.latched = ST_CSUM_ERR;
          end else begin
            nxt.size_total = sat_add(cur.size_total, cur.block_length);
            nxt.prev_block = BLK_DATA;
            nxt.phase      = PH_TYPE;
          end
        end
        PH_ELO: begin
          nxt.phase = PH_EHI;
        end
        default: begin
          nxt.phase      = PH_TYPE;
          nxt.prev_block = BLK_ENTRY;
        end
      endcase
    end
  end

  assign res.out_value   = wr ? val : 8'd0;
  assign res.out_write   = wr;
  assign res.status      = st;
  assign res.format_mode = nxt.mode;
  assign res.unique_sum  = nxt.sum_total;
  assign res.code_size   = nxt.size_total;

endmodule

@@ rtl/tape_image_block_checker.sv @@
// Cassette body checker. Feed the image body one byte per transaction on in_chan
// (leader stripped), then one transaction with end_of_image set. Every input
// transaction yields exactly one result transaction on out_chan: the byte to write
// (if out_write), the status, the detected format and the running sum and size.
// A byte is taken every cycle when out_chan keeps ready high; a result is presented
// once its byte has passed the input register and then the result register, and the
// per-byte parse state is updated as the byte moves between the two.
// The rename text register sits at byte address 0 of the APB port. The user must
// write it only while the block is idle; the block itself does not enforce this.
module tape_image_block_checker (
  input  logic               clk,
  input  logic               rst_n,
  tibc_in_if.sink            in_chan,
  tibc_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import tibc_pkg::*;

  `include "assert_macros.svh"

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_eoi_r;
  logic         out_valid_r;
  tibc_result_t out_r;
  tibc_result_t step_res;
  tibc_state_t  state_r;
  tibc_state_t  state_nxt;
  logic [47:0]  rename_text;
  logic         advance;

  tibc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rename_text (rename_text)
  );

  tibc_step u_step (
    .cur          (state_r),
    .byte_value   (s1_byte_r),
    .end_of_image (s1_eoi_r),
    .rename_text  (rename_text),
    .nxt          (state_nxt),
    .res          (step_res)
  );

  // move the held byte into the result register when that register frees up
  assign advance       = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid & in_chan.ready) begin
      s1_byte_r <= in_chan.byte_value;
      s1_eoi_r  <= in_chan.end_of_image;
    end
    if (advance) begin
      out_r <= step_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_value   = out_r.out_value;
  assign out_chan.out_write   = out_r.out_write;
  assign out_chan.status      = out_r.status;
  assign out_chan.format_mode = out_r.format_mode;
  assign out_chan.unique_sum  = out_r.unique_sum;
  assign out_chan.code_size   = out_r.code_size;

  `ASSERT_CLK(a_latched_quiet, advance && (state_r.latched != ST_BUSY) |=> !out_r.out_write, "write after latched status")
  `ASSERT_CLK(a_mode_sticky, state_r.mode != MODE_UNDECIDED |=> state_r.mode != MODE_UNDECIDED, "format mode reverted")
  `ASSERT_CLK(a_size_monotonic, advance |=> state_r.size_total >= $past(state_r.size_total), "code size decreased")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")

endmodule
